// ===== design/rac_pkg.sv =====
// Shared types, constants and helper functions for the run-length encoder.
// Holds the run record that the tracker hands to the output serializer.
// No dependencies.
`default_nettype none

package rac_pkg;

    localparam int RAC_BYTE_W   = 8;
    localparam int RAC_LEN_W    = 16;
    localparam int RAC_DIGITS   = 5;
    localparam int RAC_BCD_W    = 4 * RAC_DIGITS;
    localparam int RAC_NDIG_W   = 3;
    localparam int RAC_FIFO_DEPTH = 4;
    localparam int RAC_PTR_W    = $clog2(RAC_FIFO_DEPTH);
    localparam int RAC_CNT_W    = $clog2(RAC_FIFO_DEPTH + 1);

    localparam logic [3:0] RAC_ASCII_ZERO_HI = 4'h3;

    typedef struct packed {
        logic                  last;
        logic [RAC_NDIG_W-1:0] ndig;
        logic [RAC_BCD_W-1:0]  bcd;
        logic [RAC_BYTE_W-1:0] sym;
    } rac_rec_t;

    typedef struct packed {
        logic     push_a;
        logic     push_b;
        rac_rec_t rec_a;
        rac_rec_t rec_b;
    } rac_push_t;

    typedef struct packed {
        logic                 space_ok;
        logic                 not_empty;
        logic [RAC_CNT_W-1:0] count;
    } rac_fifo_stat_t;

    function automatic logic [RAC_BCD_W-1:0] rac_bcd_inc(input logic [RAC_BCD_W-1:0] v);
        logic [RAC_BCD_W-1:0] r;
        logic                 carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < RAC_DIGITS; i++) begin
            if (carry) begin
                if (v[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = v[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [RAC_NDIG_W-1:0] rac_ndigits(input logic [RAC_BCD_W-1:0] v);
        logic [RAC_NDIG_W-1:0] n;
        n = RAC_NDIG_W'(1);
        for (int i = 1; i < RAC_DIGITS; i++) begin
            if (v[4*i +: 4] != 4'd0) begin
                n = RAC_NDIG_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/rac_run_tracker.sv =====
// Tracks the open run: its byte, binary length and decimal length.
// Emits up to two run records per accepted item. Depends on rac_pkg.
`default_nettype none

module rac_run_tracker import rac_pkg::*; #(
    parameter int unsigned MAX_RUN = 65535
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [RAC_BYTE_W-1:0] data_byte,
    input  wire logic                  end_of_string,
    output rac_push_t                  push
);

    localparam logic [RAC_LEN_W-1:0] LIMIT = RAC_LEN_W'(MAX_RUN);

    logic [RAC_BYTE_W-1:0] sym_reg,  sym_next;
    logic [RAC_LEN_W-1:0]  len_reg,  len_next;
    logic [RAC_BCD_W-1:0]  bcd_reg,  bcd_next;
    logic                  open_reg, open_next;

    logic                  match;
    logic                  flush;
    logic [RAC_LEN_W-1:0]  len_new;
    logic [RAC_BCD_W-1:0]  bcd_new;
    logic [RAC_BYTE_W-1:0] sym_new;

    always_comb begin
        match   = open_reg && (sym_reg == data_byte);
        len_new = match ? len_reg + RAC_LEN_W'(1) : RAC_LEN_W'(1);
        bcd_new = match ? rac_bcd_inc(bcd_reg) : RAC_BCD_W'(1);
        sym_new = data_byte;
        flush   = (len_new >= LIMIT) || end_of_string;

        push.push_a      = accept && open_reg && !match;
        push.rec_a.sym   = sym_reg;
        push.rec_a.bcd   = bcd_reg;
        push.rec_a.ndig  = rac_ndigits(bcd_reg);
        push.rec_a.last  = !flush;

        push.push_b      = accept && flush;
        push.rec_b.sym   = sym_new;
        push.rec_b.bcd   = bcd_new;
        push.rec_b.ndig  = rac_ndigits(bcd_new);
        push.rec_b.last  = 1'b1;

        sym_next  = sym_reg;
        len_next  = len_reg;
        bcd_next  = bcd_reg;
        open_next = open_reg;
        if (accept) begin
            if (flush) begin
                sym_next  = '0;
                len_next  = '0;
                bcd_next  = '0;
                open_next = 1'b0;
            end else begin
                sym_next  = sym_new;
                len_next  = len_new;
                bcd_next  = bcd_new;
                open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg  <= '0;
            len_reg  <= '0;
            bcd_reg  <= '0;
            open_reg <= 1'b0;
        end else begin
            sym_reg  <= sym_next;
            len_reg  <= len_next;
            bcd_reg  <= bcd_next;
            open_reg <= open_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/rac_rec_fifo.sv =====
// Small queue of run records, two writes and one read per cycle.
// Depends on rac_pkg.
`default_nettype none

module rac_rec_fifo import rac_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire rac_push_t push,
    input  wire logic     pop,
    output rac_rec_t      head,
    output rac_fifo_stat_t stat
);

    rac_rec_t              mem_reg [RAC_FIFO_DEPTH];
    logic [RAC_PTR_W-1:0]  wr_reg, wr_next;
    logic [RAC_PTR_W-1:0]  rd_reg, rd_next;
    logic [RAC_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RAC_PTR_W-1:0]  wr_b;
    logic                  do_pop;

    always_comb begin
        do_pop   = pop && (cnt_reg != '0);
        wr_b     = wr_reg + RAC_PTR_W'(push.push_a);
        wr_next  = wr_reg + RAC_PTR_W'(push.push_a) + RAC_PTR_W'(push.push_b);
        rd_next  = rd_reg + RAC_PTR_W'(do_pop);
        cnt_next = cnt_reg + RAC_CNT_W'(push.push_a) + RAC_CNT_W'(push.push_b)
                   - RAC_CNT_W'(do_pop);
        head           = mem_reg[rd_reg];
        stat.count     = cnt_reg;
        stat.not_empty = (cnt_reg != '0);
        stat.space_ok  = (cnt_reg <= RAC_CNT_W'(RAC_FIFO_DEPTH - 2));
    end

    always_ff @(posedge aclk) begin
        if (push.push_a) begin
            mem_reg[wr_reg] <= push.rec_a;
        end
        if (push.push_b) begin
            mem_reg[wr_b] <= push.rec_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/rac_serializer.sv =====
// Turns each run record into its byte and its decimal digits, one item a cycle while records wait
// and out_ready is high, through a registered output stage. Depends on rac_pkg.
`default_nettype none

module rac_serializer import rac_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire rac_rec_t              head,
    input  wire logic                  head_valid,
    output logic                       pop,
    output logic                       out_valid,
    output logic [RAC_BYTE_W-1:0]      out_byte,
    output logic                       out_last,
    input  wire logic                  out_ready
);

    rac_rec_t              rec_reg, rec_next;
    logic                  busy_reg, busy_next;
    logic [RAC_NDIG_W-1:0] pos_reg, pos_next;
    logic                  ov_reg, ov_next;
    logic [RAC_BYTE_W-1:0] ob_reg, ob_next;
    logic                  ol_reg, ol_next;

    logic                  can_load;
    logic                  final_byte;
    logic [RAC_NDIG_W-1:0] k;
    logic [3:0]            digit;
    logic [RAC_BYTE_W-1:0] cur_byte;

    always_comb begin
        can_load   = !ov_reg || out_ready;
        final_byte = busy_reg && (pos_reg == rec_reg.ndig);
        k          = rec_reg.ndig - pos_reg;
        unique case (k)
            3'd0:    digit = rec_reg.bcd[3:0];
            3'd1:    digit = rec_reg.bcd[7:4];
            3'd2:    digit = rec_reg.bcd[11:8];
            3'd3:    digit = rec_reg.bcd[15:12];
            3'd4:    digit = rec_reg.bcd[19:16];
            default: digit = 4'd0;
        endcase
        cur_byte = (pos_reg == '0) ? rec_reg.sym : {RAC_ASCII_ZERO_HI, digit};

        pop = head_valid && (!busy_reg || (can_load && final_byte));

        rec_next  = rec_reg;
        busy_next = busy_reg;
        pos_next  = pos_reg;
        ov_next   = ov_reg;
        ob_next   = ob_reg;
        ol_next   = ol_reg;

        if (can_load) begin
            ov_next = busy_reg;
            ob_next = cur_byte;
            ol_next = final_byte && rec_reg.last;
            if (busy_reg) begin
                pos_next = pos_reg + RAC_NDIG_W'(1);
            end
            if (final_byte) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            rec_next  = head;
            busy_next = 1'b1;
            pos_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
        pos_reg <= pos_next;
        ob_reg  <= ob_next;
        ol_reg  <= ol_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;

endmodule

`default_nettype wire

// ===== design/rle_ascii_count_encoder_unit.sv =====
// Run-length encoder with ASCII decimal counts; top level of the block.
// An item is taken in any cycle in which the record queue has room for two runs.
// Each run record passes the queue, then the serializer's record and output registers.
// Results leave at one byte per cycle while records are queued and m_tready is high.
// Synchronous active-low reset closes the open run and empties the queue.
`default_nettype none

module rle_ascii_count_encoder_unit import rac_pkg::*; #(
    parameter int unsigned MAX_RUN = 65535
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // end_of_string
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last_of_burst
);

    rac_push_t      push;
    rac_rec_t       head;
    rac_fifo_stat_t stat;
    logic           pop;
    logic           accept;

    assign s_tready = stat.space_ok;
    assign accept   = s_tvalid && s_tready;

    rac_run_tracker #(
        .MAX_RUN(MAX_RUN)
    ) u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_tdata),
        .end_of_string (s_tlast),
        .push          (push)
    );

    rac_rec_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    rac_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (stat.not_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_ready  (m_tready)
    );

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= RAC_CNT_W'(RAC_FIFO_DEPTH))
        else $error("run record queue overfilled");

    a_flush_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> stat.count != '0)
        else $error("final item left no run record queued");

    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.push_a || push.push_b) |-> stat.count <= RAC_CNT_W'(RAC_FIFO_DEPTH - 2))
        else $error("run record pushed without room");
`endif

endmodule

`default_nettype wire

// ===== test/rle_ascii_count_encoder_unit_tb.sv =====
// Self-checking testbench for rle_ascii_count_encoder_unit.
// Feeds byte strings on the input stream and compares every encoded output item against a
// behavioral run-length predictor. Depends only on the RTL of the block.
`default_nettype none

module rle_ascii_count_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_RUN     = 65535;
    localparam int          MAX_GAP     = 30;
    localparam int          MAX_STALL   = 40;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RAND_ITEMS  = 300;

    typedef struct {
        logic [7:0] data;
        logic       eos;
        logic       drain;
    } src_item_t;

    typedef struct {
        logic [7:0] ch;
        logic       lst;
    } enc_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    wire        s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    wire        m_tvalid;
    logic       m_tready = 1'b0;
    wire  [7:0] m_tdata;
    wire        m_tlast;

    rle_ascii_count_encoder_unit #(.MAX_RUN(MAX_RUN)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    src_item_t   string_q[$];
    enc_byte_t   encoded_q[$];
    int unsigned mismatches  = 0;
    longint      cycle_limit = 64'd1000000000;
    longint      cycle_count = 0;
    int          hold_at     = -1;

    // Stimulus bookkeeping, used only to size the timeout.
    logic [7:0]  gen_sym     = 8'h00;
    logic        gen_closed  = 1'b1;
    int unsigned gen_len     = 0;
    int unsigned gen_runs    = 0;

    // Predictor state.
    logic [7:0]  open_sym    = 8'h00;
    int unsigned open_len    = 0;
    logic        run_is_open = 1'b0;
    logic [7:0]  step_buf[8];
    int          step_n;

    task automatic queue_byte(input logic [7:0] b, input logic eos, input logic drain);
        src_item_t it;
        if (gen_closed || b != gen_sym || gen_len >= MAX_RUN) begin
            gen_runs++;
            gen_len = 1;
        end else begin
            gen_len++;
        end
        gen_sym    = b;
        gen_closed = eos;
        it.data    = b;
        it.eos     = eos;
        it.drain   = drain;
        string_q.push_back(it);
    endtask

    task automatic queue_run(input logic [7:0] b, input int unsigned n, input logic eos);
        for (int unsigned i = 1; i < n; i++) begin
            queue_byte(b, 1'b0, 1'b0);
        end
        queue_byte(b, eos, 1'b0);
    endtask

    task automatic append_run(input logic [7:0] sym, input int unsigned len);
        logic [7:0]  digits[5];
        int          nd;
        int unsigned v;
        v  = len;
        nd = 0;
        do begin
            digits[nd] = 8'h30 + 8'(v % 10);
            v          = v / 10;
            nd++;
        end while (v != 0);
        step_buf[step_n] = sym;
        step_n++;
        for (int i = nd - 1; i >= 0; i--) begin
            step_buf[step_n] = digits[i];
            step_n++;
        end
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic eos);
        enc_byte_t e;
        step_n = 0;
        if (run_is_open && open_sym == b) begin
            open_len++;
        end else begin
            if (run_is_open) begin
                append_run(open_sym, open_len);
            end
            open_sym    = b;
            open_len    = 1;
            run_is_open = 1'b1;
        end
        if (open_len >= MAX_RUN || eos) begin
            append_run(open_sym, open_len);
            run_is_open = 1'b0;
            open_len    = 0;
            open_sym    = 8'h00;
        end
        for (int i = 0; i < step_n; i++) begin
            e.ch  = step_buf[i];
            e.lst = (i == step_n - 1);
            encoded_q.push_back(e);
        end
    endtask

    // Input driver.
    int        gap_left  = 0;
    logic      tx_steady = 1'b0;
    src_item_t tx_item;

    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (string_q.size() != 0 &&
                             (!string_q[0].drain || encoded_q.size() == 0)) begin
                    tx_item = string_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= tx_item.data;
                    s_tlast  <= tx_item.eos;
                    if ($urandom_range(0, 49) == 0) begin
                        tx_steady = !tx_steady;
                    end
                    r = $urandom_range(0, 99);
                    if (tx_steady || r < 60) begin
                        gap_left = 0;
                    end else if (r < 95) begin
                        gap_left = $urandom_range(1, 3);
                    end else begin
                        gap_left = $urandom_range(8, MAX_GAP);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready pattern, with one long hold-off once the input side has moved far enough.
    int   in_seen    = 0;
    int   hold_left  = 0;
    int   stall_left = 0;
    logic rx_steady  = 1'b0;

    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_seen++;
                if (in_seen == hold_at) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if ($urandom_range(0, 99) == 0) begin
                rx_steady = !rx_steady;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    m_tready <= 1'b1;
                end else if (r < 96) begin
                    stall_left = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(8, MAX_STALL);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // Output monitor.
    always @(posedge aclk) begin
        enc_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (encoded_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual byte %h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = encoded_q.pop_front();
                if (m_tdata !== want.ch) begin
                    $display("%0t: out_byte mismatch, expected %h, actual %h",
                             $time, want.ch, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.lst) begin
                    $display("%0t: last_of_burst mismatch, expected %b, actual %b",
                             $time, want.lst, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > cycle_limit) begin
            $display("%0t: timeout with %0d items pending and %0d results outstanding",
                     $time, string_q.size(), encoded_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int          base;
        int          nruns;
        int          r;
        int unsigned len;
        logic [7:0]  sym;
        logic        drain_next;

        queue_byte("A", 1'b1, 1'b0);
        queue_run(8'h00, 3, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b0);
        queue_byte("1", 1'b0, 1'b0);
        queue_byte("1", 1'b0, 1'b0);
        queue_byte("2", 1'b1, 1'b0);
        queue_run(8'h55, 10, 1'b0);
        queue_byte(8'hAA, 1'b1, 1'b0);
        queue_byte("B", 1'b1, 1'b0);
        queue_byte("B", 1'b1, 1'b0);
        queue_run(8'h0F, 2, 1'b0);
        queue_run(8'hF0, 1, 1'b0);
        queue_run(8'h0F, 1, 1'b1);
        queue_run(8'h80, 100, 1'b0);
        queue_byte(8'h81, 1'b1, 1'b0);

        base       = string_q.size();
        hold_at    = base + 120;
        drain_next = 1'b0;
        sym        = 8'h00;
        while (string_q.size() - base < RAND_ITEMS) begin
            if (string_q.size() - base > 250 && string_q.size() - base < 260) begin
                drain_next = 1'b1;
            end
            nruns = $urandom_range(1, 6);
            for (int k = 0; k < nruns; k++) begin
                if (k == 0 || $urandom_range(0, 3) != 0) begin
                    sym = 8'($urandom_range(0, 255));
                end
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    len = $urandom_range(1, 4);
                end else if (r < 96) begin
                    len = $urandom_range(5, 15);
                end else begin
                    len = $urandom_range(90, 130);
                end
                for (int unsigned i = 0; i < len; i++) begin
                    queue_byte(sym,
                               k == nruns - 1 && i == len - 1 && $urandom_range(0, 9) != 0,
                               drain_next);
                    drain_next = 1'b0;
                end
            end
        end

        cycle_limit = 3 * (longint'(string_q.size()) * (MAX_GAP + 4) +
                           longint'(gen_runs) * 6 * (MAX_STALL + 2) + HOLD_CYCLES) + 20000;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (string_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (encoded_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0 && encoded_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
